// ===== rtl/stpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpf_pkg
// Shared types, op codes, controller/datapath command and status structs,
// and the 5x7 font table for the page frame store text renderer.
// ----------------------------------------------------------------------------
package stpf_pkg;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int LETTER_COUNT = 26;
    localparam int GLYPH_COUNT  = 36;
    localparam int PAGE_ROWS    = 8;
    localparam int PAGE_W       = 3;
    localparam int ADDR_CMP_W   = 12;

    localparam logic [7:0] CHAR_COLON  = 8'h3a;
    localparam logic [7:0] CHAR_DASH   = 8'h2d;
    localparam logic [7:0] CHAR_DOT    = 8'h2e;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UC_A   = 8'h41;
    localparam logic [7:0] CHAR_UC_Z   = 8'h5a;
    localparam logic [7:0] CHAR_LC_A   = 8'h61;
    localparam logic [7:0] CHAR_LC_Z   = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef logic [0:GLYPH_COLS-1][GLYPH_ROWS-1:0] t_glyph;

    typedef struct packed {
        logic ready;
        logic sweep_wr;
        logic mem_rd_item;
        logic setup;
        logic page_first;
        logic page_next;
        logic col_step;
        logic mem_rd_draw;
        logic mem_wr_draw;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        t_op  op;
        logic sweep_last;
        logic drop;
        logic col_ok;
        logic col_last;
        logic page_last;
        logic out_free;
    } t_sts;

    localparam t_glyph GLYPH_BLANK = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
    localparam t_glyph GLYPH_COLON = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
    localparam t_glyph GLYPH_DASH  = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
    localparam t_glyph GLYPH_DOT   = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};

    localparam t_glyph FONT_TABLE [GLYPH_COUNT] = '{
        {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e}, {7'h7f, 7'h49, 7'h49, 7'h49, 7'h36},
        {7'h3e, 7'h41, 7'h41, 7'h41, 7'h22}, {7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c},
        {7'h7f, 7'h49, 7'h49, 7'h49, 7'h41}, {7'h7f, 7'h09, 7'h09, 7'h09, 7'h01},
        {7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a}, {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f},
        {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00}, {7'h20, 7'h40, 7'h41, 7'h3f, 7'h01},
        {7'h7f, 7'h08, 7'h14, 7'h22, 7'h41}, {7'h7f, 7'h40, 7'h40, 7'h40, 7'h40},
        {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f}, {7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f},
        {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e}, {7'h7f, 7'h09, 7'h09, 7'h09, 7'h06},
        {7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e}, {7'h7f, 7'h09, 7'h19, 7'h29, 7'h46},
        {7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01},
        {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f}, {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f},
        {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f}, {7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        {7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, {7'h61, 7'h51, 7'h49, 7'h45, 7'h43},
        {7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e}, {7'h00, 7'h42, 7'h7f, 7'h40, 7'h00},
        {7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, {7'h21, 7'h41, 7'h45, 7'h4b, 7'h31},
        {7'h18, 7'h14, 7'h12, 7'h7f, 7'h10}, {7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        {7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30}, {7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        {7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, {7'h06, 7'h49, 7'h49, 7'h29, 7'h1e}
    };

    function automatic t_glyph glyph_of(input logic [7:0] code);
        logic [7:0] folded;
        t_glyph     g;
        folded = ((code >= CHAR_LC_A) && (code <= CHAR_LC_Z)) ? code - CASE_OFFSET : code;
        priority if (code == CHAR_COLON) begin
            g = GLYPH_COLON;
        end else if (code == CHAR_DASH) begin
            g = GLYPH_DASH;
        end else if (code == CHAR_DOT) begin
            g = GLYPH_DOT;
        end else if ((folded >= CHAR_UC_A) && (folded <= CHAR_UC_Z)) begin
            g = FONT_TABLE[6'(folded - CHAR_UC_A)];
        end else if ((folded >= CHAR_0) && (folded <= CHAR_9)) begin
            g = FONT_TABLE[6'(folded - CHAR_0) + 6'(LETTER_COUNT)];
        end else begin
            g = GLYPH_BLANK;
        end
        return g;
    endfunction

endpackage

// ===== rtl/stpf_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpf_ifs
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface stpf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] char_code;
    logic       starts_string;
    logic [7:0] start_x;
    logic [5:0] start_y;
    logic [2:0] scale;
    logic [8:0] read_address;

    modport source (
        output valid, op, char_code, starts_string, start_x, start_y, scale,
               read_address,
        input  ready
    );
    modport sink (
        input  valid, op, char_code, starts_string, start_x, start_y, scale,
               read_address,
        output ready
    );
endinterface

interface stpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       char_dropped;

    modport source (output valid, read_data, char_dropped, input ready);
    modport sink (input valid, read_data, char_dropped, output ready);
endinterface

// ===== rtl/stpf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/stpf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpf_ctrl
// Sequencer: store clearing sweep, byte read, and the glyph
// read-modify-write walk over columns and pages.
// ----------------------------------------------------------------------------
module stpf_ctrl import stpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_DECODE = 10'b00_0000_0100,
        S_CLEAR  = 10'b00_0000_1000,
        S_READ   = 10'b00_0001_0000,
        S_SETUP  = 10'b00_0010_0000,
        S_COL    = 10'b00_0100_0000,
        S_RD     = 10'b00_1000_0000,
        S_WR     = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_sts.in_fire) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_CLEAR: n_state = S_CLEAR;
                    OP_DRAW:  n_state = S_SETUP;
                    OP_READ:  n_state = S_READ;
                    OP_NONE:  n_state = S_RESP;
                    default:  n_state = S_RESP;
                endcase
            end
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_RESP;
                end
            end
            S_READ: begin
                o_cmd.mem_rd_item = 1'b1;
                n_state           = S_RESP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.drop ? S_RESP : S_COL;
            end
            S_COL: begin
                if (i_sts.col_ok) begin
                    o_cmd.page_first = 1'b1;
                    n_state          = S_RD;
                end else begin
                    o_cmd.col_step = 1'b1;
                    n_state        = i_sts.col_last ? S_RESP : S_COL;
                end
            end
            S_RD: begin
                o_cmd.mem_rd_draw = 1'b1;
                n_state           = S_WR;
            end
            S_WR: begin
                o_cmd.mem_wr_draw = 1'b1;
                if (i_sts.page_last) begin
                    o_cmd.col_step = 1'b1;
                    n_state        = i_sts.col_last ? S_RESP : S_COL;
                end else begin
                    o_cmd.page_next = 1'b1;
                    n_state         = S_RD;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

endmodule

// ===== rtl/stpf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpf_dp
// Datapath: request latch, string cursor state, glyph geometry, page mask,
// frame store RAM and result register.
// ----------------------------------------------------------------------------
module stpf_dp import stpf_pkg::*; #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 32,
    parameter int MAX_SCALE      = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stpf_in_if.sink    i_req,
    stpf_out_if.source o_rsp,
    input  t_cmd       i_cmd,
    output t_sts       o_sts
);

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [9:0]            W10        = 10'(DISPLAY_WIDTH);
    localparam logic [6:0]            H7         = 7'(DISPLAY_HEIGHT);
    localparam logic [PAGE_W-1:0]     LAST_PAGE  = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [ADDR_CMP_W-1:0] STORE_CMP  = ADDR_CMP_W'(STORE_BYTES);
    localparam logic [ADDR_CMP_W-1:0] W12        = ADDR_CMP_W'(DISPLAY_WIDTH);
    localparam logic [3:0]            MAX_SC     = 4'(MAX_SCALE);
    localparam logic [AW-1:0]         SWEEP_LAST = AW'(STORE_BYTES - 1);
    localparam logic [2:0]            LAST_COL   = 3'(GLYPH_COLS - 1);

    // latched request
    t_op         r_op;
    logic [7:0]  r_code;
    logic        r_starts;
    logic [7:0]  r_sx;
    logic [5:0]  r_sy;
    logic [2:0]  r_sc;
    logic        r_rd_ok;
    logic [AW-1:0] r_rd_addr;

    // string state
    logic [8:0]  r_cursor;
    logic [5:0]  r_row;
    logic [2:0]  r_scale;
    logic        r_ended;

    // glyph walk
    t_glyph      r_glyph;
    logic [6:0]  r_bound [GLYPH_ROWS+1];
    logic [PAGE_W-1:0] r_p0;
    logic [PAGE_W-1:0] r_p1;
    logic        r_pages_ok;
    logic [2:0]  r_col;
    logic [2:0]  r_dx;
    logic [9:0]  r_px;
    logic [PAGE_W-1:0] r_page;
    logic        r_dropped;

    logic [AW-1:0] r_sweep;

    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_dropped;

    // setup terms
    logic [2:0]  sat_sc;
    logic [2:0]  eff_scale;
    logic [8:0]  eff_cursor;
    logic [5:0]  eff_row;
    logic        eff_ended;
    logic        drop;
    logic [9:0]  cur_sum;
    logic [8:0]  n_cursor;
    logic [9:0]  end_sum;
    logic        n_ended;
    logic [6:0]  n_bound [GLYPH_ROWS+1];
    logic [6:0]  last_row;
    logic [3:0]  p1_raw;
    logic [PAGE_W-1:0] n_p1;

    logic [GLYPH_ROWS-1:0] col_bits;
    logic [7:0]  mask;
    logic [ADDR_CMP_W-1:0] draw_addr_w;
    logic [AW-1:0] draw_addr;
    logic [ADDR_CMP_W-1:0] req_addr_w;
    logic        dx_wrap;
    logic        in_fire;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    always_comb begin
        sat_sc     = ({1'b0, r_sc} > MAX_SC) ? MAX_SC[2:0] : r_sc;
        eff_scale  = r_starts ? sat_sc : r_scale;
        eff_cursor = r_starts ? {1'b0, r_sx} : r_cursor;
        eff_row    = r_starts ? r_sy : r_row;
        eff_ended  = r_starts ? 1'b0 : r_ended;
        drop       = eff_ended || (eff_scale == 3'd0);
        cur_sum    = 10'(eff_cursor) + 10'(6'(eff_scale) * 6'd6);
        n_cursor   = cur_sum[8:0];
        end_sum    = 10'(n_cursor) + 10'(6'(eff_scale) * 6'd5);
        n_ended    = end_sum >= W10;
        for (int k = 0; k <= GLYPH_ROWS; k++) begin
            n_bound[k] = 7'(eff_row) + 7'(k) * 7'(eff_scale);
        end
        last_row = n_bound[GLYPH_ROWS] - 7'd1;
        p1_raw   = last_row[6:3];
        n_p1     = (p1_raw > {1'b0, LAST_PAGE}) ? LAST_PAGE : p1_raw[PAGE_W-1:0];
    end

    // page mask: rows of this page covered by a set font pixel of the column
    always_comb begin
        logic [6:0] py;
        logic       hit;
        col_bits = r_glyph[r_col];
        for (int b = 0; b < PAGE_ROWS; b++) begin
            py  = {1'b0, r_page, 3'(b)};
            hit = 1'b0;
            for (int r = 0; r < GLYPH_ROWS; r++) begin
                hit = hit | (col_bits[r] & (py >= r_bound[r]) & (py < r_bound[r+1]));
            end
            mask[b] = hit & (py < H7);
        end
    end

    assign draw_addr_w = ADDR_CMP_W'(r_px) + ADDR_CMP_W'(r_page) * W12;
    assign draw_addr   = draw_addr_w[AW-1:0];
    assign req_addr_w  = ADDR_CMP_W'(i_req.read_address);
    assign dx_wrap     = r_dx == (r_scale - 3'd1);
    assign in_fire     = i_req.valid & i_cmd.ready;

    assign ram_wr_en   = i_cmd.sweep_wr | i_cmd.mem_wr_draw;
    assign ram_wr_addr = i_cmd.sweep_wr ? r_sweep : draw_addr;
    assign ram_wr_data = i_cmd.sweep_wr ? 8'd0 : (ram_rd_data | mask);
    assign ram_rd_en   = i_cmd.mem_rd_item | i_cmd.mem_rd_draw;
    assign ram_rd_addr = i_cmd.mem_rd_item ? r_rd_addr : draw_addr;

    stpf_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // request latch and glyph walk payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op      <= t_op'(i_req.op);
            r_code    <= i_req.char_code;
            r_starts  <= i_req.starts_string;
            r_sx      <= i_req.start_x;
            r_sy      <= i_req.start_y;
            r_sc      <= i_req.scale;
            r_rd_ok   <= req_addr_w < STORE_CMP;
            r_rd_addr <= req_addr_w[AW-1:0];
        end
        if (i_cmd.setup) begin
            r_glyph    <= glyph_of(r_code);
            r_bound    <= n_bound;
            r_p0       <= eff_row[5:3];
            r_p1       <= n_p1;
            r_pages_ok <= eff_row[5:3] <= LAST_PAGE;
            r_col      <= 3'd0;
            r_dx       <= 3'd0;
            r_px       <= 10'(eff_cursor);
            r_dropped  <= drop;
        end
        if (i_cmd.col_step) begin
            r_px <= r_px + 10'd1;
            if (dx_wrap) begin
                r_dx  <= 3'd0;
                r_col <= r_col + 3'd1;
            end else begin
                r_dx <= r_dx + 3'd1;
            end
        end
        if (i_cmd.page_first) begin
            r_page <= r_p0;
        end else if (i_cmd.page_next) begin
            r_page <= r_page + PAGE_W'(1);
        end
        if (i_cmd.respond) begin
            r_out_data    <= ((r_op == OP_READ) && r_rd_ok) ? ram_rd_data : 8'd0;
            r_out_dropped <= (r_op == OP_DRAW) && r_dropped;
        end
    end

    // string state, sweep counter, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= 9'd0;
            r_row       <= 6'd0;
            r_scale     <= 3'd0;
            r_ended     <= 1'b1;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.setup) begin
                r_row   <= eff_row;
                r_scale <= eff_scale;
                if (drop) begin
                    r_cursor <= eff_cursor;
                    r_ended  <= 1'b1;
                end else begin
                    r_cursor <= n_cursor;
                    r_ended  <= n_ended;
                end
            end
            if (i_cmd.sweep_wr) begin
                r_sweep <= (r_sweep == SWEEP_LAST) ? '0 : r_sweep + AW'(1);
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready        = i_cmd.ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_data;
    assign o_rsp.char_dropped = r_out_dropped;

    always_comb begin
        o_sts            = '0;
        o_sts.in_fire    = in_fire;
        o_sts.op         = r_op;
        o_sts.sweep_last = r_sweep == SWEEP_LAST;
        o_sts.drop       = drop;
        o_sts.col_ok     = (r_px < W10) && r_pages_ok;
        o_sts.col_last   = (r_col == LAST_COL) && dx_wrap;
        o_sts.page_last  = r_page == r_p1;
        o_sts.out_free   = !r_out_valid || o_rsp.ready;
    end

    a_respond_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.respond |-> (!r_out_valid || o_rsp.ready))
        else $error("result loaded over an untaken beat");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr_draw |-> $past(i_cmd.mem_rd_draw))
        else $error("store write without preceding read");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr_draw |-> ((r_px < W10) && (r_page <= LAST_PAGE)))
        else $error("draw write outside the display");

    a_drop_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.setup && drop) |=> r_ended)
        else $error("dropped character left the string open");

endmodule

// ===== rtl/scaled_text_to_page_framebuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_text_to_page_framebuffer
// Renders scaled 5x7 text into a page-organised monochrome frame store and
// reads store bytes back in flush order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    op, char_code, starts_string, start_x,
//                                start_y, scale, read_address
//  o_rsp     out  valid/ready    read_data, char_dropped
//
//  One item at a time; one result beat per item, held in an output register.
//  Clear: zero sweep of the store (one zero write per cycle on the RAM port).
//  Read: one registered store read. Draw: a step per pixel column (5 * scale
//  of them) and a store read and write per page for each on-screen column,
//  one read-modify-write each. After reset the store is swept to zero; no item
//  is taken meanwhile. A stalled result delays the next result and later items.
// ----------------------------------------------------------------------------
module scaled_text_to_page_framebuffer import stpf_pkg::*; #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 32,
    parameter int MAX_SCALE      = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stpf_in_if.sink    i_req,
    stpf_out_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    stpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stpf_dp #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .MAX_SCALE      (MAX_SCALE)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
